### rtl/hexp_pkg.sv
package hexp_pkg;

    // Characters with a meaning of their own in the listing.
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [3:0] DIGIT_TEN = 4'hA;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ZERO,
        PH_HIGH,
        PH_FAIL
    } phase_t;

    // Classification of one character.
    typedef struct packed {
        logic       is_sep;
        logic       is_zero;
        logic       is_x;
        logic       is_hex;
        logic [3:0] digit;
    } char_class_t;

    // One result as it leaves the parser.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       status;
        logic       done_res;
    } parse_result_t;

endpackage

### rtl/hexp_if.sv
interface hexp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface hexp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
    logic       done_res;

    modport source (output valid, output out_byte, output byte_valid, output status,
                    output done_res, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input done_res, output ready);
endinterface

### rtl/hexp_char_class.sv
module hexp_char_class (
    input  logic [7:0]                text_char,
    output hexp_pkg::char_class_t     char_class
);
    import hexp_pkg::*;

    logic is_dec;
    logic is_uc;
    logic is_lc;

    assign is_dec = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
    assign is_uc  = (text_char >= CH_UC_A) && (text_char <= CH_UC_F);
    assign is_lc  = (text_char >= CH_LC_A) && (text_char <= CH_LC_F);

    always_comb
    begin
        char_class.is_sep  = (text_char == CH_COMMA) || (text_char == CH_SPACE) ||
                             (text_char == CH_CR) || (text_char == CH_LF) ||
                             (text_char == CH_LBRACE) || (text_char == CH_RBRACE);
        char_class.is_zero = (text_char == CH_ZERO);
        char_class.is_x    = (text_char == CH_LC_X) || (text_char == CH_UC_X);
        char_class.is_hex  = is_dec || is_uc || is_lc;
        if (is_dec)
        begin
            char_class.digit = text_char[3:0];
        end
        else if (is_uc)
        begin
            char_class.digit = 4'(text_char - CH_UC_A) + DIGIT_TEN;
        end
        else if (is_lc)
        begin
            char_class.digit = 4'(text_char - CH_LC_A) + DIGIT_TEN;
        end
        else
        begin
            char_class.digit = 4'h0;
        end
    end

endmodule

### rtl/hexp_parse_fsm.sv
module hexp_parse_fsm (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  hexp_pkg::char_class_t     char_class,
    input  logic                      last_char,
    output hexp_pkg::parse_result_t   result
);
    import hexp_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     phase_step;
    phase_t     phase_end;
    logic [3:0] high_nibble_reg;
    logic [3:0] high_nibble_next;
    logic [3:0] nibble_step;

    // Next state: one step of the token grammar, then the end-of-file rules.
    always_comb
    begin
        phase_step  = phase_reg;
        nibble_step = high_nibble_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (char_class.is_sep)
                begin
                    phase_step = PH_IDLE;
                end
                else if (char_class.is_zero)
                begin
                    phase_step  = PH_ZERO;
                    nibble_step = 4'h0;
                end
                else if (char_class.is_hex)
                begin
                    phase_step  = PH_HIGH;
                    nibble_step = char_class.digit;
                end
                else
                begin
                    phase_step = PH_FAIL;
                end
            end
            PH_ZERO:
            begin
                if (char_class.is_x || char_class.is_hex)
                begin
                    phase_step = PH_IDLE;
                end
                else
                begin
                    phase_step = PH_FAIL;
                end
            end
            PH_HIGH:
            begin
                phase_step = char_class.is_hex ? PH_IDLE : PH_FAIL;
            end
            PH_FAIL:
            begin
                phase_step = PH_FAIL;
            end
            default:
            begin
                phase_step = PH_FAIL;
            end
        endcase

        // A file that stops inside a token is malformed.
        if (last_char && ((phase_step == PH_ZERO) || (phase_step == PH_HIGH)))
        begin
            phase_end = PH_FAIL;
        end
        else
        begin
            phase_end = phase_step;
        end

        if (last_char)
        begin
            phase_next       = PH_IDLE;
            high_nibble_next = 4'h0;
        end
        else
        begin
            phase_next       = phase_end;
            high_nibble_next = nibble_step;
        end
    end

    // Outputs: a byte completes on the second digit of a pair.
    always_comb
    begin
        result.out_byte   = 8'h00;
        result.byte_valid = 1'b0;
        unique case (phase_reg)
            PH_ZERO:
            begin
                if (!char_class.is_x && char_class.is_hex)
                begin
                    result.out_byte   = {4'h0, char_class.digit};
                    result.byte_valid = 1'b1;
                end
            end
            PH_HIGH:
            begin
                if (char_class.is_hex)
                begin
                    result.out_byte   = {high_nibble_reg, char_class.digit};
                    result.byte_valid = 1'b1;
                end
            end
            PH_IDLE, PH_FAIL:
            begin
                result.byte_valid = 1'b0;
            end
            default:
            begin
                result.byte_valid = 1'b0;
            end
        endcase
        result.status   = (phase_end == PH_FAIL);
        result.done_res = last_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            high_nibble_reg <= 4'h0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
        end
    end

endmodule

### rtl/hex_text_to_byte_parser.sv
// The block reads a C-array style hex listing one character per request on
// in_ch (text_char, with last_char marking the final character of a file)
// and returns exactly one result per character on out_ch: out_byte with
// byte_valid set when the character completes a pair of hex digits, status
// set once a format error has been seen in the current file, and done_res
// echoing last_char. Separators, braces and "0x" prefixes yield a result
// with byte_valid low.
//
// The result is registered: a character accepted at a clock edge has its
// result on out_ch in the cycle after. Throughput is one character per
// cycle while out_ch is not stalled; the character decode and parser state
// update sit between the parser state register and the output register.
//
// The output register is a single stage, and in_ch stays ready whenever it
// is empty or being emptied in the same cycle, so a stalled receiver holds
// the pending result and back-pressures the sender without losing anything.
// Reset clears the parser to idle between tokens with no error and empties
// the output register. After the last character of a file the parser
// returns to that same state, ready for the next file.
module hex_text_to_byte_parser (
    input  logic        clk,
    input  logic        rst_n,
    hexp_in_if.sink     in_ch,
    hexp_out_if.source  out_ch
);
    import hexp_pkg::*;

    char_class_t   char_class;
    parse_result_t result;
    parse_result_t result_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          accept;

    // The output stage can take a new result when empty or draining now.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    hexp_char_class u_char_class (
        .text_char  (in_ch.text_char),
        .char_class (char_class)
    );

    hexp_parse_fsm u_parse_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_class (char_class),
        .last_char  (in_ch.last_char),
        .result     (result)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = result_reg.out_byte;
    assign out_ch.byte_valid = result_reg.byte_valid;
    assign out_ch.status     = result_reg.status;
    assign out_ch.done_res   = result_reg.done_res;

endmodule

### dv/tb.sv
// Testbench for the hex text to byte parser.
//
// A queue of character requests is built at time zero: a short directed part
// that walks through the awkward corners of the listing format, then random
// files that are mostly well formed with random content, with a share of
// broken and noisy files mixed in. A feeder process pops requests from that
// queue and offers them on in_ch. A collector process takes results from
// out_ch. Both sides pause at random between requests.
//
// Every character taken by the block is run through a local parser that
// keeps its own phase and pending high digit. The parser appends the
// expected result to a queue, and each result that leaves the block is
// checked field by field against the oldest entry.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hexp_pkg::*;

    localparam int RANDOM_CHARS = 1950;
    localparam int LONG_HOLD    = 400;   // cycles of receiver hold-off
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int MAX_REPORTS  = 20;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } char_req_t;

    logic clk = 1'b0;
    logic rst_n;

    hexp_in_if  in_ch ();
    hexp_out_if out_ch ();

    hex_text_to_byte_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    // Requests waiting to be offered, and results that the parser owes us.
    char_req_t     chars_to_send[$];
    parse_result_t parse_results_due[$];

    // Local copy of the parser state. It starts as reset leaves the block.
    phase_t     parse_phase = PH_IDLE;
    logic [3:0] pend_high   = 4'h0;

    // Handshake bookkeeping. The collector and long_stall write these at the
    // rising edge; the feeder and the receiver read them at the falling edge.
    logic char_taken   = 1'b0;
    logic result_taken = 1'b0;
    logic hold_off     = 1'b0;

    int total_chars   = 0;
    int chars_seen    = 0;
    int results_seen  = 0;
    int bytes_seen    = 0;
    int files_closed  = 0;
    int files_failed  = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    // ------------------------------------------------------------------
    // Expected behaviour of the parser for one character.
    // ------------------------------------------------------------------
    task automatic parse_char(input logic [7:0] ch, input logic last,
                              output parse_result_t res);
        logic       is_sep;
        logic       is_hex;
        logic [3:0] digit;
        begin
            is_sep = (ch == CH_COMMA) || (ch == CH_SPACE) || (ch == CH_CR) ||
                     (ch == CH_LF) || (ch == CH_LBRACE) || (ch == CH_RBRACE);
            is_hex = 1'b1;
            digit  = 4'h0;
            if (ch >= CH_ZERO && ch <= CH_NINE)
                digit = 4'(ch - CH_ZERO);
            else if (ch >= CH_UC_A && ch <= CH_UC_F)
                digit = 4'(ch - CH_UC_A) + DIGIT_TEN;
            else if (ch >= CH_LC_A && ch <= CH_LC_F)
                digit = 4'(ch - CH_LC_A) + DIGIT_TEN;
            else
                is_hex = 1'b0;

            res = '0;
            case (parse_phase)
                PH_IDLE:
                begin
                    // Separators between tokens are skipped. A leading zero
                    // may open a prefix or a one-digit byte.
                    if (is_sep)
                        parse_phase = PH_IDLE;
                    else if (ch == CH_ZERO)
                    begin
                        parse_phase = PH_ZERO;
                        pend_high   = 4'h0;
                    end
                    else if (is_hex)
                    begin
                        parse_phase = PH_HIGH;
                        pend_high   = digit;
                    end
                    else
                        parse_phase = PH_FAIL;
                end
                PH_ZERO:
                begin
                    if (ch == CH_LC_X || ch == CH_UC_X)
                        parse_phase = PH_IDLE;
                    else if (is_hex)
                    begin
                        res.out_byte   = {4'h0, digit};
                        res.byte_valid = 1'b1;
                        parse_phase    = PH_IDLE;
                    end
                    else
                        parse_phase = PH_FAIL;
                end
                PH_HIGH:
                begin
                    if (is_hex)
                    begin
                        res.out_byte   = {pend_high, digit};
                        res.byte_valid = 1'b1;
                        parse_phase    = PH_IDLE;
                    end
                    else
                        parse_phase = PH_FAIL;
                end
                default:
                    parse_phase = PH_FAIL;
            endcase

            // A file that stops half way through a token is malformed.
            if (last && (parse_phase == PH_ZERO || parse_phase == PH_HIGH))
                parse_phase = PH_FAIL;

            res.status   = (parse_phase == PH_FAIL);
            res.done_res = last;

            if (last)
            begin
                parse_phase = PH_IDLE;
                pend_high   = 4'h0;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        begin
            if (mismatches < MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] ch, input logic last);
        char_req_t req;
        begin
            req.text_char = ch;
            req.last_char = last;
            chars_to_send.push_back(req);
        end
    endtask

    task automatic push_text(input string s, input logic close_file);
        begin
            for (int i = 0; i < s.len(); i++)
                push_char(s[i], close_file && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] hex_char(input int value, input logic upper);
        if (value < 10)
            return CH_ZERO + 8'(value);
        return (upper ? CH_UC_A : CH_LC_A) + 8'(value - 10);
    endfunction

    function automatic logic [7:0] random_sep();
        case ($urandom_range(0, 5))
            0:       return CH_COMMA;
            1:       return CH_SPACE;
            2:       return CH_CR;
            3:       return CH_LF;
            4:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // One random file. Most are well formed: optional prefixes (sometimes
    // doubled), two-digit or zero-led one-digit bytes in mixed case, and
    // random runs of separators. About three in twenty are then damaged, and a
    // few are pure noise over the whole character range.
    task automatic add_random_file();
        logic [7:0] text[$];
        int         flavour;
        int         n_tokens;
        int         pos;
        begin
            flavour = $urandom_range(0, 99);
            if (flavour >= 95)
            begin
                repeat ($urandom_range(1, 12))
                    text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    text.push_back(CH_LBRACE);
                n_tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
                for (int t = 0; t < n_tokens; t++)
                begin
                    repeat ($urandom_range(0, 3))
                        text.push_back(random_sep());
                    repeat (($urandom_range(0, 9) < 5) ? 1 : $urandom_range(0, 2))
                    begin
                        text.push_back(CH_ZERO);
                        text.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
                    end
                    if ($urandom_range(0, 7) == 0)
                    begin
                        text.push_back(CH_ZERO);
                        text.push_back(hex_char($urandom_range(0, 15),
                                                1'($urandom_range(0, 1))));
                    end
                    else
                    begin
                        text.push_back(hex_char($urandom_range(0, 15),
                                                1'($urandom_range(0, 1))));
                        text.push_back(hex_char($urandom_range(0, 15),
                                                1'($urandom_range(0, 1))));
                    end
                end
                case ($urandom_range(0, 3))
                    0:       text.push_back(CH_RBRACE);
                    1:       text.push_back(CH_LF);
                    default: ;
                endcase

                if (flavour >= 80)
                begin
                    pos = $urandom_range(0, text.size() - 1);
                    case ($urandom_range(0, 4))
                        0: text[pos] = 8'($urandom_range(0, 255));
                        1: text[pos] = 8'($urandom_range(128, 255));
                        2: text.push_back(hex_char($urandom_range(0, 15), 1'b1));
                        3: text.push_back(CH_ZERO);
                        default:
                        begin
                            // A separator splits a token in two.
                            text.push_back(hex_char($urandom_range(0, 15), 1'b0));
                            text.push_back(random_sep());
                            text.push_back(hex_char($urandom_range(0, 15), 1'b0));
                            text.push_back(hex_char($urandom_range(0, 15), 1'b1));
                        end
                    endcase
                end
            end

            foreach (text[i])
                push_char(text[i], i == text.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and the end of the run.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.text_char  = 8'h00;
        in_ch.last_char  = 1'b0;
        out_ch.ready     = 1'b0;

        // A tidy file with braces, space, CR LF, a doubled prefix in both
        // cases, a zero-led byte and digits of both cases.
        push_text("{0x0f, FF", 1'b0);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b0);
        push_text("0X0xa9}", 1'b1);
        // A separator after a high digit, then characters after the error.
        push_text("1 G", 1'b1);
        // A separator after a leading zero.
        push_text("0,", 1'b1);
        // Files that stop inside a token.
        push_text("7", 1'b1);
        push_text("0", 1'b1);
        // A byte of all ones is just a bad character.
        push_char(CH_ZERO, 1'b0);
        push_char(8'hFF, 1'b1);
        push_char(8'h00, 1'b1);

        while (chars_to_send.size() < RANDOM_CHARS + 25)
            add_random_file();
        total_chars = chars_to_send.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sampled at the falling edge, clear of the collector's updates.
        while (chars_seen < total_chars || parse_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d characters in %0d files; %0d bytes came back and %0d files",
                 chars_seen, files_closed, bytes_seen, files_failed);
        $display("ended with a format error; %0d results were checked.", results_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Feeder: offers requests on in_ch at the falling edge. A request stays
    // on the bus until it has been taken, then a random gap follows. Now
    // and then the feeder switches to bursts with no gaps at all.
    // ------------------------------------------------------------------
    int   send_gap   = 0;
    logic send_burst = 1'b0;
    logic in_busy    = 1'b0;

    always @(negedge clk)
    begin : feeder
        char_req_t req;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (char_taken)
            begin
                char_taken = 1'b0;
                in_busy    = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 15);
            end
            if (!in_busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (chars_to_send.size() > 0)
                begin
                    req = chars_to_send.pop_front();
                    in_ch.text_char <= req.text_char;
                    in_ch.last_char <= req.last_char;
                    in_ch.valid     <= 1'b1;
                    in_busy = 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drives out_ch.ready at the falling edge, with a random gap
    // after each result taken, bursts of full speed, and the long hold-off
    // below that makes the block fill up and stall its input.
    // ------------------------------------------------------------------
    int   take_gap   = 0;
    logic take_burst = 1'b0;

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    take_burst = ~take_burst;
                take_gap = take_burst ? 0 : $urandom_range(0, 15);
            end
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (take_gap > 0)
            begin
                take_gap--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Two long hold-offs, one early and one late in the run. The feeder
    // carries on offering throughout.
    initial
    begin : long_stall
        for (int n = 1; n <= 2; n++)
        begin
            while (chars_seen < n * 600)
                @(negedge clk);
            @(posedge clk);
            hold_off = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_off = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Collector: at each rising edge, check a result that has been taken,
    // then predict for a character that has been taken. The result taken
    // at an edge always belongs to an earlier character, so this order is
    // the right one. It also keeps the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : collector
        parse_result_t got;
        parse_result_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (out_ch.valid && out_ch.ready)
            begin
                idle_cycles  = 0;
                result_taken = 1'b1;
                got.out_byte   = out_ch.out_byte;
                got.byte_valid = out_ch.byte_valid;
                got.status     = out_ch.status;
                got.done_res   = out_ch.done_res;
                if (parse_results_due.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no character pending",
                                              results_seen));
                else
                begin
                    want = parse_results_due.pop_front();
                    if (got.out_byte !== want.out_byte)
                        report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                                  results_seen, got.out_byte, want.out_byte));
                    if (got.byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("result %0d byte_valid %b, expected %b",
                                                  results_seen, got.byte_valid,
                                                  want.byte_valid));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status %b, expected %b",
                                                  results_seen, got.status, want.status));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("result %0d done_res %b, expected %b",
                                                  results_seen, got.done_res, want.done_res));
                end
                results_seen++;
                if (got.byte_valid === 1'b1)
                    bytes_seen++;
                if (got.done_res === 1'b1)
                begin
                    files_closed++;
                    if (got.status === 1'b1)
                        files_failed++;
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                idle_cycles = 0;
                char_taken  = 1'b1;
                parse_char(in_ch.text_char, in_ch.last_char, want);
                parse_results_due.push_back(want);
                chars_seen++;
            end

            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timed out after %0d cycles with no request taken on either side.",
                         IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
